// File: rtl/core/gwf_pkg.sv
// Package for the grid wall follower: command, status and heading codes,
// the configuration struct and the neighbour and turn helper functions.
// Depends on nothing; used by every module of the block.
package gwf_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W   = 4;
    localparam int GRID_W    = 5;
    localparam int MOVES_W   = 16;
    localparam int FIELD_MAX = 16;   // rows and columns that a 4-bit field can name

    localparam int MAX_GRID_DEF = 16;

    localparam logic [GRID_W-1:0]  GRID_MIN        = 5'd3;
    localparam logic [GRID_W-1:0]  GRID_RESET      = 5'd12;
    localparam logic [MOVES_W-1:0] STEP_LIMIT_RESET = 16'd900;

    // Configuration register indexes.
    localparam logic REG_GRID_SIZE  = 1'b0;
    localparam logic REG_STEP_LIMIT = 1'b1;

    // Commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    // Headings.
    localparam logic [1:0] HD_EAST  = 2'd0;
    localparam logic [1:0] HD_NORTH = 2'd1;
    localparam logic [1:0] HD_SOUTH = 2'd2;
    localparam logic [1:0] HD_WEST  = 2'd3;

    // Walk status.
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WALK     = 3'd1;
    localparam logic [2:0] PH_EXIT     = 3'd2;
    localparam logic [2:0] PH_GAVE_UP  = 3'd3;
    localparam logic [2:0] PH_NO_ENTRY = 3'd4;

    typedef struct packed {
        logic [GRID_W-1:0]  grid_size;
        logic [MOVES_W-1:0] step_limit;
    } cfg_t;

    typedef struct packed {
        logic               in_grid;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } cell_t;

    function automatic logic [1:0] right_of(logic [1:0] h);
        logic [1:0] r;
        case (h)
            HD_EAST:  r = HD_SOUTH;
            HD_NORTH: r = HD_EAST;
            HD_SOUTH: r = HD_WEST;
            default:  r = HD_NORTH;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] left_of(logic [1:0] h);
        logic [1:0] l;
        case (h)
            HD_EAST:  l = HD_NORTH;
            HD_NORTH: l = HD_WEST;
            HD_SOUTH: l = HD_EAST;
            default:  l = HD_SOUTH;
        endcase
        return l;
    endfunction

    // With this coding the opposite heading is the bitwise complement.
    function automatic logic [1:0] back_of(logic [1:0] h);
        return ~h;
    endfunction

    // Heading tried at position k of the right-hand order.
    function automatic logic [1:0] try_heading(logic [1:0] h, logic [1:0] k);
        logic [1:0] t;
        case (k)
            2'd0:    t = right_of(h);
            2'd1:    t = h;
            2'd2:    t = left_of(h);
            default: t = back_of(h);
        endcase
        return t;
    endfunction

    // Neighbouring cell in direction h, flagged when it lies inside a grid of g.
    function automatic cell_t neighbour(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                                        logic [1:0] h, logic [GRID_W-1:0] g);
        logic [GRID_W-1:0] nr;
        logic [GRID_W-1:0] nc;
        logic              neg;
        cell_t             n;
        nr  = {1'b0, r};
        nc  = {1'b0, c};
        neg = 1'b0;
        case (h)
            HD_EAST:  nc = nc + 5'd1;
            HD_NORTH:
            begin
                neg = (r == '0);
                nr  = nr - 5'd1;
            end
            HD_SOUTH: nr = nr + 5'd1;
            default:
            begin
                neg = (c == '0);
                nc  = nc - 5'd1;
            end
        endcase
        n.in_grid = !neg && (nr < g) && (nc < g);
        n.row     = nr[COORD_W-1:0];
        n.col     = nc[COORD_W-1:0];
        return n;
    endfunction

endpackage

// File: rtl/core/gwf_wall_mem.sv
// Wall map storage: one bit per cell, one write port and one read port
// with registered read data. Depends on gwf_pkg for the default grid bound.
module gwf_wall_mem #(
    parameter  int MAX_GRID = gwf_pkg::MAX_GRID_DEF,
    localparam int Use      = (MAX_GRID < gwf_pkg::FIELD_MAX) ? MAX_GRID : gwf_pkg::FIELD_MAX,
    localparam int Depth    = Use * Use,
    localparam int AddrW    = $clog2(Depth)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic             wdata,
    input  logic [AddrW-1:0] raddr,
    output logic             rdata
);

    logic wall_mem [Depth];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            wall_mem[waddr] <= wdata;
        end
        rdata_reg <= wall_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/gwf_walk_ctrl.sv
// Walk sequencer: clearing pass, cell writes, entry scan, right-hand steps
// and the output register. Reads and writes the map in gwf_wall_mem;
// depends on gwf_pkg.
module gwf_walk_ctrl #(
    parameter  int MAX_GRID = gwf_pkg::MAX_GRID_DEF,
    localparam int Use      = (MAX_GRID < gwf_pkg::FIELD_MAX) ? MAX_GRID : gwf_pkg::FIELD_MAX,
    localparam int Depth    = Use * Use,
    localparam int AddrW    = $clog2(Depth)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gwf_pkg::cfg_t       cfg,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic [3:0]          cell_row,
    input  logic [3:0]          cell_col,
    input  logic                is_wall,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          walker_row,
    output logic [3:0]          walker_col,
    output logic [1:0]          facing,
    output logic [15:0]         moves_taken,
    output logic [2:0]          walk_status,

    output logic                mem_we,
    output logic [AddrW-1:0]    mem_waddr,
    output logic                mem_wdata,
    output logic [AddrW-1:0]    mem_raddr,
    input  logic                mem_rdata
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_STEP  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    localparam logic [gwf_pkg::GRID_W-1:0] GridTop = gwf_pkg::GRID_W'(Use);

    state_t            state_reg, state_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [AddrW-1:0]  clr_reg, clr_next;
    logic              inside_reg, inside_next;
    logic [3:0]        row_reg, row_next;
    logic [3:0]        col_reg, col_next;
    logic [1:0]        head_reg, head_next;
    logic [15:0]       moves_reg, moves_next;
    logic [2:0]        phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic [3:0]        out_row_reg;
    logic [3:0]        out_col_reg;
    logic [1:0]        out_head_reg;
    logic [15:0]       out_moves_reg;
    logic [2:0]        out_phase_reg;
    logic              load_out;

    logic [gwf_pkg::GRID_W-1:0] g;
    gwf_pkg::cell_t    cand;
    gwf_pkg::cell_t    mv;
    logic [1:0]        prev_head;
    logic [1:0]        new_head;
    logic              open_prev;
    logic [3:0]        new_col;

    function automatic logic [AddrW-1:0] cell_addr(logic [3:0] r, logic [3:0] c);
        return AddrW'(int'(r) * Use + int'(c));
    endfunction

    // Grid size in use, held between GRID_MIN and the largest size that the storage supports.
    always_comb
    begin
        if (cfg.grid_size < gwf_pkg::GRID_MIN)
        begin
            g = gwf_pkg::GRID_MIN;
        end
        else if (cfg.grid_size > GridTop)
        begin
            g = GridTop;
        end
        else
        begin
            g = cfg.grid_size;
        end
    end

    // Step search: the candidate of cnt_reg is read while the one before is checked.
    assign cand      = gwf_pkg::neighbour(row_reg, col_reg,
                           gwf_pkg::try_heading(head_reg, cnt_reg[1:0]), g);
    assign prev_head = gwf_pkg::try_heading(head_reg, cnt_reg[1:0] - 2'd1);
    assign open_prev = inside_reg && !mem_rdata;
    assign new_head  = open_prev ? prev_head : gwf_pkg::back_of(head_reg);
    assign mv        = gwf_pkg::neighbour(row_reg, col_reg, new_head, g);
    assign new_col   = mv.in_grid ? mv.col : col_reg;

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        inside_next = cand.in_grid;
        row_next    = row_reg;
        col_next    = col_reg;
        head_next   = head_reg;
        moves_next  = moves_reg;
        phase_next  = phase_reg;
        mem_we      = 1'b0;
        mem_waddr   = cell_addr(cell_row, cell_col);
        mem_wdata   = is_wall;
        mem_raddr   = cell_addr(cand.row, cand.col);

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AddrW'(Depth - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DONE;
                    case (command)
                        gwf_pkg::CMD_WRITE:
                        begin
                            // Cells beyond the storage are dropped.
                            mem_we = (int'(cell_row) < Use) && (int'(cell_col) < Use);
                        end
                        gwf_pkg::CMD_START:
                        begin
                            row_next   = '0;
                            col_next   = 4'd1;
                            head_next  = gwf_pkg::HD_EAST;
                            moves_next = '0;
                            phase_next = gwf_pkg::PH_NO_ENTRY;
                            cnt_next   = '0;
                            state_next = ST_SCAN;
                        end
                        gwf_pkg::CMD_STEP:
                        begin
                            if (phase_reg == gwf_pkg::PH_WALK)
                            begin
                                if (moves_reg >= cfg.step_limit)
                                begin
                                    phase_next = gwf_pkg::PH_GAVE_UP;
                                end
                                else
                                begin
                                    cnt_next   = '0;
                                    state_next = ST_STEP;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                mem_raddr = cell_addr(cnt_reg[3:0], 4'd0);
                if ((cnt_reg != '0) && !mem_rdata)
                begin
                    row_next   = 4'(cnt_reg - 5'd1);
                    phase_next = gwf_pkg::PH_WALK;
                    state_next = ST_DONE;
                end
                else if (cnt_reg == g)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_STEP:
            begin
                if ((cnt_reg != '0) && (open_prev || (cnt_reg == 5'd3)))
                begin
                    // Boxed in, the walker turns back; the move counts even if it stays put.
                    head_next = new_head;
                    if (mv.in_grid)
                    begin
                        row_next = mv.row;
                        col_next = mv.col;
                    end
                    moves_next = moves_reg + 16'd1;
                    if ({1'b0, new_col} >= (g - 5'd1))
                    begin
                        phase_next = gwf_pkg::PH_EXIT;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            inside_reg    <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            head_reg      <= gwf_pkg::HD_EAST;
            moves_reg     <= '0;
            phase_reg     <= gwf_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            inside_reg    <= inside_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            head_reg      <= head_next;
            moves_reg     <= moves_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
            out_head_reg  <= head_reg;
            out_moves_reg <= moves_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign walker_row  = out_row_reg;
    assign walker_col  = out_col_reg;
    assign facing      = out_head_reg;
    assign moves_taken = out_moves_reg;
    assign walk_status = out_phase_reg;

    // The map is written only by the clearing pass or by an accepted write.
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("map written outside the clearing pass or a write transaction");

    // A new result only ever comes out of the done state.
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == ST_DONE))
        else $error("result register loaded outside the done state");

    // The step search never runs past the turn-back candidate.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (cnt_reg <= 5'd3))
        else $error("step search ran past four candidates");

    // The entry scan stops at the last row of the grid in use.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= g))
        else $error("entry scan ran beyond the grid");

endmodule

// File: rtl/core/grid_wall_follower.sv
// Grid wall follower: right-hand walker over a map of wall bits.
// Each accepted command gives one result: a cell write or a step that does not move goes straight to the done state,
// a step reads the map once per candidate heading (pipelined), and a start reads it
// once per row of column 0.
// One transaction is in work at a time; the next is taken the cycle after its result is loaded.
// After reset the map is cleared, all min(MAX_GRID,16)^2 cells, with input stalled.
module grid_wall_follower #(
    parameter int MAX_GRID = gwf_pkg::MAX_GRID_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [3:0]  cell_row,
    input  logic [3:0]  cell_col,
    input  logic        is_wall,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  walker_row,
    output logic [3:0]  walker_col,
    output logic [1:0]  facing,
    output logic [15:0] moves_taken,
    output logic [2:0]  walk_status
);

    localparam int Use   = (MAX_GRID < gwf_pkg::FIELD_MAX) ? MAX_GRID : gwf_pkg::FIELD_MAX;
    localparam int AddrW = $clog2(Use * Use);

    logic [4:0]    grid_size_reg;
    logic [15:0]   step_limit_reg;
    gwf_pkg::cfg_t cfg;

    logic             mem_we;
    logic [AddrW-1:0] mem_waddr;
    logic             mem_wdata;
    logic [AddrW-1:0] mem_raddr;
    logic             mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= gwf_pkg::GRID_RESET;
            step_limit_reg <= gwf_pkg::STEP_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gwf_pkg::REG_GRID_SIZE:  grid_size_reg  <= cfg_data[4:0];
                gwf_pkg::REG_STEP_LIMIT: step_limit_reg <= cfg_data;
                default:                 grid_size_reg  <= grid_size_reg;
            endcase
        end
    end

    assign cfg.grid_size  = grid_size_reg;
    assign cfg.step_limit = step_limit_reg;

    gwf_walk_ctrl #(
        .MAX_GRID (MAX_GRID)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .is_wall     (is_wall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .walker_row  (walker_row),
        .walker_col  (walker_col),
        .facing      (facing),
        .moves_taken (moves_taken),
        .walk_status (walk_status),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    gwf_wall_mem #(
        .MAX_GRID (MAX_GRID)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
